// ===== rtl/gsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsr_pkg: shared constants and types for the shift-reduce recognizer
// Sizes of the symbol stack and production table, beat field widths,
// mode codes and the sequencer state type.
// ----------------------------------------------------------------------------
package gsr_pkg;

  // Sizing
  localparam int STACK_DEPTH       = 32;
  localparam int MAX_PRODUCTIONS   = 16;
  localparam int MAX_RIGHT_SYMBOLS = 6;

  // Fixed field widths
  localparam int SYM_W    = 8;
  localparam int RIGHT_W  = 48;
  localparam int RLEN_W   = 3;
  localparam int IDX_W    = 4;
  localparam int MODE_W   = 2;
  localparam int PCFG_W   = 5;
  localparam int DEPTH_W  = 6;
  localparam int DONE_W   = 5;

  // Derived widths
  localparam int STACK_AW = $clog2(STACK_DEPTH);
  localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
  localparam int PROD_AW  = (MAX_PRODUCTIONS > 1) ? $clog2(MAX_PRODUCTIONS) : 1;
  localparam int PCNT_W   = $clog2(MAX_PRODUCTIONS + 1);
  localparam int LEN_W    = $clog2(MAX_RIGHT_SYMBOLS + 1);
  localparam int TBL_R_W  = MAX_RIGHT_SYMBOLS * SYM_W;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SHIFT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_CMP,
    ST_TOP,
    ST_RES
  } gsr_state_t;

endpackage

// ===== rtl/greedy_shift_reduce_recognizer_unit.sv =====
`timescale 1ns / 1ps
// Sequence: a shift or finish beat steps through ST_PROD, then ST_CMP for each stack symbol
//   compared (at most 6 per production), over the active productions, then ST_TOP and
//   ST_RES; a load beat writes the table entry in ST_IDLE and gives no result.
// Throughput: one beat at a time; in_stall is high outside ST_IDLE, so after a shift or finish
//   a new beat waits until the result is handed on (longer on a stall), a load takes one the next cycle.
// Reset: synchronous, active low; empties the stack and clears the production count.
// ----------------------------------------------------------------------------
// greedy_shift_reduce_recognizer_unit: greedy shift-reduce recognizer
// Holds a loaded production table and a symbol stack in RAM. Each shift or
// finish beat runs one ordered reduce pass with a single byte comparator.
// Table entries hold garbage until loaded.
// ----------------------------------------------------------------------------
module greedy_shift_reduce_recognizer_unit
  import gsr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [PCFG_W-1:0]   cfg_wr_data,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [IDX_W-1:0]    in_entry_index,
  input  logic [SYM_W-1:0]    in_left_symbol,
  input  logic [RLEN_W-1:0]   in_right_length,
  input  logic [RIGHT_W-1:0]  in_right_symbols,
  input  logic [SYM_W-1:0]    in_input_symbol,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DEPTH_W-1:0]  out_stack_depth,
  output logic [SYM_W-1:0]    out_top_symbol,
  output logic [DONE_W-1:0]   out_reductions_done,
  output logic                out_overflow,
  output logic                out_finished,
  output logic                out_accepted
);

  // Production table
  logic [SYM_W-1:0]   prod_left_r  [MAX_PRODUCTIONS];
  logic [LEN_W-1:0]   prod_len_r   [MAX_PRODUCTIONS];
  logic [TBL_R_W-1:0] prod_right_r [MAX_PRODUCTIONS];
  logic [PCFG_W-1:0]  prod_count_r;

  // Sequencer state
  gsr_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [PCNT_W-1:0]  p_r, p_nxt;
  logic [LEN_W-1:0]   k_r, k_nxt;
  logic [CNT_W-1:0]   base_r, base_nxt;
  logic [DONE_W-1:0]  done_r, done_nxt;
  logic               ovf_r, ovf_nxt;
  logic               fin_r, fin_nxt;

  // Result register
  logic               out_valid_r;
  logic [DEPTH_W-1:0] out_depth_r;
  logic [SYM_W-1:0]   out_top_r;
  logic [DONE_W-1:0]  out_done_r;
  logic               out_ovf_r;
  logic               out_fin_r;
  logic               out_acc_r;

  // Stack RAM ports
  logic                ram_we;
  logic [STACK_AW-1:0] ram_waddr;
  logic [SYM_W-1:0]    ram_wdata;
  logic [STACK_AW-1:0] ram_raddr;
  logic [SYM_W-1:0]    ram_rdata;

  // Helpers
  logic                tbl_we;
  logic                load_out;
  logic [PROD_AW-1:0]  p_idx;
  logic [PROD_AW-1:0]  load_idx;
  logic [LEN_W-1:0]    cur_len;
  logic [TBL_R_W-1:0]  cur_right;
  logic [SYM_W-1:0]    want;
  logic [CNT_W-1:0]    cur_base;
  logic [CNT_W-1:0]    next_rd;
  logic [CNT_W-1:0]    count_m1;
  logic [PCNT_W-1:0]   limit;
  logic [LEN_W-1:0]    in_len_clamp;
  logic                idx_ok;

  gsr_ram #(
    .WIDTH (SYM_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Table entry under the pass pointer
  assign p_idx     = p_r[PROD_AW-1:0];
  assign cur_len   = prod_len_r[p_idx];
  assign cur_right = prod_right_r[p_idx];
  assign want      = cur_right[SYM_W*k_r +: SYM_W];
  assign cur_base  = count_r - CNT_W'(cur_len);
  assign next_rd   = base_r + CNT_W'(k_r) + CNT_W'(1);
  assign count_m1  = count_r - CNT_W'(1);

  // Active production count, capped at the table size
  assign limit = (32'(prod_count_r) > MAX_PRODUCTIONS) ? PCNT_W'(MAX_PRODUCTIONS)
                                                       : PCNT_W'(prod_count_r);

  // Load beat: clamp the right side length, drop out-of-table indexes
  always_comb begin
    if (in_right_length == '0) begin
      in_len_clamp = LEN_W'(1);
    end else if (32'(in_right_length) > MAX_RIGHT_SYMBOLS) begin
      in_len_clamp = LEN_W'(MAX_RIGHT_SYMBOLS);
    end else begin
      in_len_clamp = LEN_W'(in_right_length);
    end
  end
  assign idx_ok   = (32'(in_entry_index) < MAX_PRODUCTIONS);
  assign load_idx = PROD_AW'(in_entry_index);

  // Sequencer: next state and datapath controls
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    p_nxt     = p_r;
    k_nxt     = k_r;
    base_nxt  = base_r;
    done_nxt  = done_r;
    ovf_nxt   = ovf_r;
    fin_nxt   = fin_r;
    ram_we    = 1'b0;
    ram_waddr = count_r[STACK_AW-1:0];
    ram_wdata = in_input_symbol;
    ram_raddr = count_m1[STACK_AW-1:0];
    tbl_we    = 1'b0;
    load_out  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            MODE_LOAD: begin
              tbl_we = idx_ok;
            end
            MODE_SHIFT: begin
              p_nxt    = '0;
              done_nxt = '0;
              fin_nxt  = 1'b0;
              if (32'(count_r) < STACK_DEPTH) begin
                ram_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                ovf_nxt   = 1'b0;
              end else begin
                ovf_nxt = 1'b1;
              end
              state_nxt = ST_PROD;
            end
            MODE_FINISH: begin
              p_nxt     = '0;
              done_nxt  = '0;
              fin_nxt   = 1'b1;
              ovf_nxt   = 1'b0;
              state_nxt = ST_PROD;
            end
            default: begin
            end
          endcase
        end
      end

      // Pick the next production; start its compare at the deepest symbol
      ST_PROD: begin
        if (p_r >= limit) begin
          state_nxt = ST_TOP;
        end else if (count_r < CNT_W'(cur_len)) begin
          p_nxt = p_r + PCNT_W'(1);
        end else begin
          base_nxt  = cur_base;
          k_nxt     = '0;
          ram_raddr = cur_base[STACK_AW-1:0];
          state_nxt = ST_CMP;
        end
      end

      // One stack symbol against one right-side symbol per cycle
      ST_CMP: begin
        if (ram_rdata != want) begin
          p_nxt     = p_r + PCNT_W'(1);
          state_nxt = ST_PROD;
        end else if (LEN_W'(k_r + LEN_W'(1)) == cur_len) begin
          ram_we    = 1'b1;
          ram_waddr = base_r[STACK_AW-1:0];
          ram_wdata = prod_left_r[p_idx];
          count_nxt = base_r + CNT_W'(1);
          if (done_r != '1) begin
            done_nxt = done_r + DONE_W'(1);
          end
          p_nxt     = p_r + PCNT_W'(1);
          state_nxt = ST_PROD;
        end else begin
          k_nxt     = k_r + LEN_W'(1);
          ram_raddr = next_rd[STACK_AW-1:0];
        end
      end

      // Fetch the top symbol
      ST_TOP: begin
        state_nxt = ST_RES;
      end

      // Hand the result to the output register once it is free
      ST_RES: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      p_r          <= '0;
      done_r       <= '0;
      ovf_r        <= 1'b0;
      fin_r        <= 1'b0;
      prod_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      p_r     <= p_nxt;
      done_r  <= done_nxt;
      ovf_r   <= ovf_nxt;
      fin_r   <= fin_nxt;
      if (cfg_wr_en) begin
        prod_count_r <= cfg_wr_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: compare pointer, table, result fields
  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    base_r <= base_nxt;
    if (tbl_we) begin
      prod_left_r[load_idx]  <= in_left_symbol;
      prod_len_r[load_idx]   <= in_len_clamp;
      prod_right_r[load_idx] <= TBL_R_W'(in_right_symbols);
    end
    if (load_out) begin
      out_depth_r <= DEPTH_W'(count_r);
      out_top_r   <= (count_r == '0) ? '0 : ram_rdata;
      out_done_r  <= done_r;
      out_ovf_r   <= ovf_r;
      out_fin_r   <= fin_r;
      out_acc_r   <= fin_r && (count_r == CNT_W'(1)) && (ram_rdata == prod_left_r[0]);
    end
  end

  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_stack_depth     = out_depth_r;
  assign out_top_symbol      = out_top_r;
  assign out_reductions_done = out_done_r;
  assign out_overflow        = out_ovf_r;
  assign out_finished        = out_fin_r;
  assign out_accepted        = out_acc_r;

endmodule

// ===== rtl/gsr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsr_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module gsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/gsr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsr_checker: port-level checks for the shift-reduce recognizer
// Watches the result channel for consistency of the reported fields.
// ----------------------------------------------------------------------------
module gsr_checker
  import gsr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [DEPTH_W-1:0] out_stack_depth,
  input logic [SYM_W-1:0]   out_top_symbol,
  input logic               out_overflow,
  input logic               out_finished,
  input logic               out_accepted
);

  // A held result beat keeps its depth, top symbol and accept flag
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_stack_depth)
                                  && $stable(out_top_symbol) && $stable(out_accepted)))
    else $error("result beat changed while stalled");

  // Acceptance only on a finish, with exactly one symbol left
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_accepted) |-> (out_finished && out_stack_depth == DEPTH_W'(1)))
    else $error("accept without finish or single symbol");

  // Overflow only on a shift that found the stack full (a pass cannot grow it)
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (!out_finished && !out_accepted))
    else $error("overflow flagged on a finish beat");

  // Empty stack reports a zero top symbol; depth never exceeds the stack
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((32'(out_stack_depth) <= STACK_DEPTH)
                   && (out_stack_depth != '0 || out_top_symbol == '0)))
    else $error("stack depth or top symbol inconsistent");

endmodule

bind greedy_shift_reduce_recognizer_unit gsr_checker u_gsr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_stack_depth (out_stack_depth),
  .out_top_symbol  (out_top_symbol),
  .out_overflow    (out_overflow),
  .out_finished    (out_finished),
  .out_accepted    (out_accepted)
);
